// File: design/tcbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbs_pkg
// Shared types and constants of the TCB spline segment sampler.
// ----------------------------------------------------------------------------
package tcbs_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int SHAPE_FRAC_DEF  = 14;
    localparam int SHAPE_W         = 16;   // tension, continuity, bias width
    localparam int B_W             = 20;   // second multiplier operand width
    localparam int SPP_W           = 5;
    localparam int TV_W            = 17;   // t, t^2, t^3, t_step
    localparam int CFG_AW          = 1;
    localparam int CFG_DW          = 17;

    localparam logic [TV_W-1:0]   T_ONE       = 17'h10000;
    localparam logic [SPP_W-1:0]  SPP_RESET   = 5'd16;
    localparam logic [TV_W-1:0]   TSTEP_RESET = 17'd4096;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_SPP   = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_TSTEP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_POST,
        S_EMIT,
        S_ENDPT,
        S_WIN
    } t_state;

    typedef enum logic [3:0] {
        OP_G1A,
        OP_G2A,
        OP_HA,
        OP_TA,
        OP_G1B,
        OP_G2B,
        OP_HB,
        OP_TB,
        OP_T2,
        OP_T3,
        OP_H00,
        OP_H10,
        OP_H01,
        OP_H11
    } t_op;

    typedef struct packed {
        logic load;      // latch the incoming knot
        t_op  op;
        logic mul;       // register the product
        logic post;      // round, saturate tangent results and write back
        logic seg;       // 0: pending segment, 1: closing segment
        logic t_clr;
        logic t_adv;
        logic emit;      // load the output register
        logic emit_end;  // emitted point is the final knot itself
        logic last;
        logic win;       // update the knot window
    } t_cmd;

    typedef struct packed {
        logic [1:0] knots_seen;
        logic       final_knot;
        logic       out_free;
    } t_stat;

endpackage

// File: design/tcbs_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbs_lane
// One coordinate lane: shared multiplier, rounding, tangents and accumulator.
// ----------------------------------------------------------------------------
module tcbs_lane #(
    parameter int COORD_WIDTH     = tcbs_pkg::COORD_WIDTH_DEF,
    parameter int SHAPE_FRAC_BITS = tcbs_pkg::SHAPE_FRAC_DEF
) (
    input  logic                              i_clk,
    input  tcbs_pkg::t_cmd                    i_cmd,
    input  logic signed [COORD_WIDTH-1:0]     i_p0,
    input  logic signed [COORD_WIDTH-1:0]     i_p1,
    input  logic signed [COORD_WIDTH-1:0]     i_p2,
    input  logic signed [COORD_WIDTH-1:0]     i_p3,
    input  logic                              i_hp0,
    input  logic                              i_hp3,
    input  logic signed [tcbs_pkg::B_W-1:0]   i_b,
    input  logic [tcbs_pkg::TV_W-1:0]         i_t,
    input  logic [tcbs_pkg::TV_W-1:0]         i_t2,
    output logic [tcbs_pkg::TV_W-1:0]         o_t_raw,
    output logic signed [COORD_WIDTH-1:0]     o_point
);
    import tcbs_pkg::*;

    localparam int TW  = COORD_WIDTH + 8;
    localparam int AW  = TW;
    localparam int PW  = AW + B_W;
    localparam int ACW = PW + 2;

    localparam logic [PW-1:0] HALF_F  = PW'(1) << (SHAPE_FRAC_BITS - 1);
    localparam logic [PW-1:0] HALF_F1 = PW'(1) << SHAPE_FRAC_BITS;
    localparam logic [PW-1:0] HALF_16 = PW'(1) << 15;

    function automatic logic signed [TW-1:0] sat_tw(input logic signed [PW-1:0] v);
        logic [PW-TW:0] top;
        top = v[PW-1:TW-1];
        if (&top || ~|top) begin
            return v[TW-1:0];
        end
        return v[PW-1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_cw(
        input logic signed [ACW-1:0] v);
        logic [ACW-COORD_WIDTH:0] top;
        top = v[ACW-1:COORD_WIDTH-1];
        if (&top || ~|top) begin
            return v[COORD_WIDTH-1:0];
        end
        return v[ACW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                        : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    endfunction

    logic signed [COORD_WIDTH:0] d01, d12, d23;
    logic signed [TW:0]          dif, sum;
    logic signed [AW-1:0]        a;
    logic signed [PW-1:0]        r_prod;
    logic [PW-1:0]               mag, rnd;
    logic signed [PW-1:0]        raw;
    logic signed [TW-1:0]        rsat;
    logic                        neg;
    logic signed [TW-1:0]        r_g1, r_g2, r_h, r_ta, r_tb;
    logic signed [ACW-1:0]       r_acc;

    assign d01 = i_hp0 ? ($signed({i_p1[COORD_WIDTH-1], i_p1})
                        - $signed({i_p0[COORD_WIDTH-1], i_p0})) : '0;
    assign d12 = $signed({i_p2[COORD_WIDTH-1], i_p2}) - $signed({i_p1[COORD_WIDTH-1], i_p1});
    assign d23 = i_hp3 ? ($signed({i_p3[COORD_WIDTH-1], i_p3})
                        - $signed({i_p2[COORD_WIDTH-1], i_p2})) : '0;

    assign dif = $signed({r_g2[TW-1], r_g2}) - $signed({r_g1[TW-1], r_g1});
    assign sum = $signed({r_g1[TW-1], r_g1}) + $signed({r_h[TW-1], r_h});

    always_comb begin
        unique case (i_cmd.op)
            OP_G1A:        a = AW'(d01);
            OP_G2A:        a = AW'(d12);
            OP_G1B:        a = AW'(d12);
            OP_G2B:        a = AW'(d23);
            OP_HA, OP_HB:  a = sat_tw(PW'(dif));
            OP_TA, OP_TB:  a = sat_tw(PW'(sum));
            OP_T2:         a = $signed({{(AW-TV_W){1'b0}}, i_t});
            OP_T3:         a = $signed({{(AW-TV_W){1'b0}}, i_t2});
            OP_H00:        a = AW'(i_p1);
            OP_H10:        a = r_ta;
            OP_H01:        a = AW'(i_p2);
            OP_H11:        a = r_tb;
            default:       a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PW'(a * i_b);
        end
    end

    // round half away from zero at the op's shift
    assign neg = r_prod[PW-1];
    assign mag = neg ? PW'(-r_prod) : r_prod;

    always_comb begin
        case (i_cmd.op)
            OP_HA, OP_HB:                    rnd = (mag + HALF_F1) >> (SHAPE_FRAC_BITS + 1);
            OP_G1A, OP_G2A, OP_TA,
            OP_G1B, OP_G2B, OP_TB:           rnd = (mag + HALF_F) >> SHAPE_FRAC_BITS;
            default:                         rnd = (mag + HALF_16) >> 16;
        endcase
    end

    assign raw  = neg ? -$signed(rnd) : $signed(rnd);
    assign rsat = sat_tw(raw);

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            case (i_cmd.op)
                OP_G1A, OP_G1B: r_g1 <= rsat;
                OP_G2A, OP_G2B: r_g2 <= rsat;
                OP_HA, OP_HB:   r_h  <= rsat;
                OP_TA:          r_ta <= rsat;
                OP_TB:          r_tb <= rsat;
                OP_H00:         r_acc <= ACW'(raw);
                OP_H10, OP_H01, OP_H11: r_acc <= r_acc + ACW'(raw);
                default: ;
            endcase
        end
    end

    assign o_t_raw = raw[TV_W-1:0];
    assign o_point = sat_cw(r_acc);

endmodule

// File: design/tcbs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbs_dp
// Datapath: knot window, operand selection, three lanes, t and output register.
// ----------------------------------------------------------------------------
module tcbs_dp #(
    parameter int COORD_WIDTH     = tcbs_pkg::COORD_WIDTH_DEF,
    parameter int SHAPE_FRAC_BITS = tcbs_pkg::SHAPE_FRAC_DEF,
    parameter int IN_DW           = 144,
    parameter int OUT_DW          = 96
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcbs_pkg::t_cmd                i_cmd,
    output tcbs_pkg::t_stat               o_stat,
    input  logic [tcbs_pkg::TV_W-1:0]     i_t_step,
    input  logic [IN_DW-1:0]              i_in_data,
    input  logic                          i_in_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [OUT_DW-1:0]             o_out_data,
    output logic                          o_out_last,
    output logic                          o_out_done
);
    import tcbs_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0]      r_wpos [3][3];
    logic signed [SHAPE_W-1:0] r_wshp [3][3];
    logic [1:0]                r_ks;
    logic signed [CW-1:0]      r_q    [3];
    logic signed [SHAPE_W-1:0] r_qs   [3];
    logic                      r_final;
    logic [TV_W-1:0]           r_t, r_t2, r_t3;
    logic [TV_W:0]             t_sum;
    logic                      r_ovalid;
    logic [OUT_DW-1:0]         r_odata, n_odata;
    logic                      r_olast, r_odone;

    logic signed [SHAPE_W-1:0] s1 [3];
    logic signed [SHAPE_W-1:0] s2 [3];
    logic signed [B_W-1:0]     b, one, h00, h10, h01, h11, tv, t2v, t3v;
    logic                      hp0;
    logic [TV_W-1:0]           t_raw [3];
    logic signed [CW-1:0]      pt    [3];

    assign one = B_W'(1) << SHAPE_FRAC_BITS;
    assign tv  = $signed({{(B_W-TV_W){1'b0}}, r_t});
    assign t2v = $signed({{(B_W-TV_W){1'b0}}, r_t2});
    assign t3v = $signed({{(B_W-TV_W){1'b0}}, r_t3});
    assign h00 = B_W'(2 * t3v - 3 * t2v + $signed({{(B_W-TV_W){1'b0}}, T_ONE}));
    assign h10 = B_W'(t3v - 2 * t2v + tv);
    assign h01 = B_W'(3 * t2v - 2 * t3v);
    assign h11 = t3v - t2v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s1[k] = i_cmd.seg ? r_wshp[2][k] : r_wshp[1][k];
            s2[k] = i_cmd.seg ? r_qs[k]      : r_wshp[2][k];
        end
    end

    assign hp0 = i_cmd.seg ? (r_ks >= 2'd2) : (r_ks == 2'd3);

    // shape index: 0 tension, 1 continuity, 2 bias
    always_comb begin
        unique case (i_cmd.op)
            OP_G1A:       b = one + B_W'(s1[2]);
            OP_G2A:       b = one - B_W'(s1[2]);
            OP_HA:        b = one + B_W'(s1[1]);
            OP_TA:        b = one - B_W'(s1[0]);
            OP_G1B:       b = one + B_W'(s2[2]);
            OP_G2B:       b = one - B_W'(s2[2]);
            OP_HB:        b = one - B_W'(s2[1]);
            OP_TB:        b = one - B_W'(s2[0]);
            OP_T2, OP_T3: b = tv;
            OP_H00:       b = h00;
            OP_H10:       b = h10;
            OP_H01:       b = h01;
            OP_H11:       b = h11;
            default:      b = '0;
        endcase
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        tcbs_lane #(
            .COORD_WIDTH     (COORD_WIDTH),
            .SHAPE_FRAC_BITS (SHAPE_FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_p0    (i_cmd.seg ? r_wpos[1][k] : r_wpos[0][k]),
            .i_p1    (i_cmd.seg ? r_wpos[2][k] : r_wpos[1][k]),
            .i_p2    (i_cmd.seg ? r_q[k]       : r_wpos[2][k]),
            .i_p3    (r_q[k]),
            .i_hp0   (hp0),
            .i_hp3   (!i_cmd.seg),
            .i_b     (b),
            .i_t     (r_t),
            .i_t2    (r_t2),
            .o_t_raw (t_raw[k]),
            .o_point (pt[k])
        );
    end

    // incoming knot
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k]  <= i_in_data[k*CW +: CW];
                r_qs[k] <= i_in_data[3*CW + k*SHAPE_W +: SHAPE_W];
            end
            r_final <= i_in_last;
        end
    end

    // knot window, newest at index 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks <= 2'd0;
        end else if (i_cmd.win) begin
            if (r_final) begin
                r_ks <= 2'd0;
            end else if (r_ks != 2'd3) begin
                r_ks <= r_ks + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.win && !r_final) begin
            for (int k = 0; k < 3; k++) begin
                r_wpos[0][k] <= r_wpos[1][k];
                r_wpos[1][k] <= r_wpos[2][k];
                r_wpos[2][k] <= r_q[k];
                r_wshp[0][k] <= r_wshp[1][k];
                r_wshp[1][k] <= r_wshp[2][k];
                r_wshp[2][k] <= r_qs[k];
            end
        end
    end

    // sample parameter, saturating at one
    assign t_sum = {1'b0, r_t} + {1'b0, i_t_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t <= '0;
        end else if (i_cmd.t_clr) begin
            r_t <= '0;
        end else if (i_cmd.t_adv) begin
            r_t <= (t_sum >= {1'b0, T_ONE}) ? T_ONE : t_sum[TV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post && i_cmd.op == OP_T2) begin
            r_t2 <= t_raw[0];
        end
        if (i_cmd.post && i_cmd.op == OP_T3) begin
            r_t3 <= t_raw[0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_comb begin
        n_odata = '0;
        for (int k = 0; k < 3; k++) begin
            n_odata[k*CW +: CW] = i_cmd.emit_end ? r_q[k] : pt[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= n_odata;
            r_olast <= i_cmd.last;
            r_odone <= i_cmd.emit_end;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_last  = r_olast;
    assign o_out_done  = r_odone;

    assign o_stat.knots_seen = r_ks;
    assign o_stat.final_knot = r_final;
    assign o_stat.out_free   = !r_ovalid || i_out_ready;

endmodule

// File: design/tcbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbs_ctrl
// Controller: sequences segments, tangent ops, sample ops and emits.
// ----------------------------------------------------------------------------
module tcbs_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tcbs_pkg::SPP_W-1:0]  i_spp,
    input  tcbs_pkg::t_stat             i_stat,
    output tcbs_pkg::t_cmd              o_cmd
);
    import tcbs_pkg::*;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic             r_seg, n_seg;
    logic [SPP_W-1:0] r_i, n_i;
    logic             seg_end, i_last;

    assign i_last = ({1'b0, r_i} + 6'd1) == {1'b0, i_spp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_G1A;
            r_seg   <= 1'b0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_seg   <= n_seg;
            r_i     <= n_i;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_seg   = r_seg;
        n_i     = r_i;
        seg_end = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_op = OP_G1A;
                if (i_stat.knots_seen >= 2'd2) begin
                    n_seg   = 1'b0;
                    n_state = S_MUL;
                end else if (i_stat.final_knot && i_stat.knots_seen != 2'd0) begin
                    n_seg   = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_WIN;
                end
            end
            S_MUL: begin
                n_state = S_POST;
            end
            S_POST: begin
                if (r_op == OP_G1A) begin
                    n_i = '0;
                end
                if (r_op == OP_TB) begin
                    if (i_spp == '0) begin
                        seg_end = 1'b1;
                    end else begin
                        n_op    = OP_T2;
                        n_state = S_MUL;
                    end
                end else if (r_op == OP_H11) begin
                    n_state = S_EMIT;
                end else begin
                    n_op    = t_op'(4'(r_op) + 4'd1);
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    if (i_last) begin
                        seg_end = 1'b1;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_op    = OP_T2;
                        n_state = S_MUL;
                    end
                end
            end
            S_ENDPT: begin
                if (i_stat.out_free) begin
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // after the pending segment a final knot still closes the curve
        if (seg_end) begin
            if (!r_seg && i_stat.final_knot) begin
                n_seg   = 1'b1;
                n_op    = OP_G1A;
                n_state = S_MUL;
            end else if (r_seg) begin
                n_state = S_ENDPT;
            end else begin
                n_state = S_WIN;
            end
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = r_op;
        o_cmd.seg      = r_seg;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_POST: begin
                o_cmd.post  = 1'b1;
                o_cmd.t_clr = (r_op == OP_G1A);
            end
            S_EMIT: begin
                o_cmd.emit  = i_stat.out_free;
                o_cmd.t_adv = i_stat.out_free;
                o_cmd.last  = i_last && !r_seg && !i_stat.final_knot;
            end
            S_ENDPT: begin
                o_cmd.emit     = i_stat.out_free;
                o_cmd.emit_end = 1'b1;
                o_cmd.last     = 1'b1;
            end
            S_WIN: begin
                o_cmd.win = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// File: design/tcb_spline_segment_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_spline_segment_sampler
// Kochanek-Bartels spline sampler: knots in, Hermite points out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid / tready           knot x,y,z,tension,cont,bias; tlast=final
//  m_axis    out  tvalid / tready           point x,y,z; tlast=run_last; tuser=done
//  cfg       in   i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
//  One knot at a time. Each segment first runs its tangent ops, then each
//  sample runs six ops on one multiplier per coordinate lane (a multiply
//  step and a post step each) plus the emit; after a final knot the
//  endpoint is emitted as well.
//  A stalled output holds the sequencer in its emit or endpoint step only.
//  Synchronous active-low reset; no clearing pass after reset.
// ----------------------------------------------------------------------------
module tcb_spline_segment_sampler #(
    parameter int COORD_WIDTH     = tcbs_pkg::COORD_WIDTH_DEF,
    parameter int SHAPE_FRAC_BITS = tcbs_pkg::SHAPE_FRAC_DEF,
    localparam int IN_DW  = ((3*COORD_WIDTH + 3*tcbs_pkg::SHAPE_W + 7) / 8) * 8,
    localparam int OUT_DW = ((3*COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_DW-1:0]              s_axis_tdata,  // x, y, z, tension, cont, bias
    input  logic                          s_axis_tlast,  // final_knot
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_DW-1:0]             m_axis_tdata,  // point x, y, z
    output logic                          m_axis_tlast,  // run_last
    output logic                          m_axis_tuser,  // curve_done
    input  logic                          i_cfg_we,
    input  logic [tcbs_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [tcbs_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import tcbs_pkg::*;

    logic [SPP_W-1:0] r_spp;
    logic [TV_W-1:0]  r_t_step;
    t_cmd             cmd;
    t_stat            stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp    <= SPP_RESET;
            r_t_step <= TSTEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SPP:   r_spp    <= i_cfg_wdata[SPP_W-1:0];
                CFG_TSTEP: r_t_step <= i_cfg_wdata[TV_W-1:0];
                default: ;
            endcase
        end
    end

    tcbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_spp      (r_spp),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcbs_dp #(
        .COORD_WIDTH     (COORD_WIDTH),
        .SHAPE_FRAC_BITS (SHAPE_FRAC_BITS),
        .IN_DW           (IN_DW),
        .OUT_DW          (OUT_DW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_t_step    (r_t_step),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_done  (m_axis_tuser)
    );

endmodule

// File: design/tcbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbs_checker
// Port-level checks of the spline sampler, bound to the top level.
// ----------------------------------------------------------------------------
module tcbs_checker #(
    parameter int COORD_WIDTH = tcbs_pkg::COORD_WIDTH_DEF,
    localparam int OUT_DW = ((3*COORD_WIDTH + 7) / 8) * 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_DW-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              m_axis_tuser
);

    // hold a stalled point
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("curve endpoint not marked last");

    a_one_knot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("knot taken while previous one in work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not idle after reset");

endmodule

bind tcb_spline_segment_sampler tcbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tcbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tcb_spline_segment_sampler_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_spline_segment_sampler_chk
// Watches the knot, point and register ports of the spline sampler. It keeps
// its own knot window and Hermite arithmetic, queues the points that every
// accepted knot should produce, and compares each point transfer against the
// oldest queued point.
// ----------------------------------------------------------------------------
module tcb_spline_segment_sampler_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_knot_valid,
    input  logic                          i_knot_ready,
    input  logic [143:0]                  i_knot_data,
    input  logic                          i_knot_final,
    input  logic                          i_pt_valid,
    input  logic                          i_pt_ready,
    input  logic [95:0]                   i_pt_data,
    input  logic                          i_pt_last,
    input  logic                          i_pt_done,
    input  logic                          i_cfg_we,
    input  logic [tcbs_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [tcbs_pkg::CFG_DW-1:0]   i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import tcbs_pkg::*;

    localparam int TANW = 40;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
        logic        done;
    } point_t;

    point_t       curve_pts[$];
    longint       win_pos[3][3];
    longint       win_shape[3][3];
    int           knot_cnt;
    logic [4:0]   seg_samples;
    logic [16:0]  t_inc;
    longint       tan_out[3];
    longint       tan_in[3];
    int           fails;

    assign o_fail_count = fails;
    assign o_pending    = curve_pts.size();

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // round a*b/2^n half away from zero, clamp to w bits
    function automatic longint mul_rnd(longint a, longint b, int n, int w);
        logic signed [127:0] p;
        logic [127:0]        mag;
        logic [127:0]        lim;
        bit                  neg;
        p   = $signed(a) * $signed(b);
        neg = p < 0;
        mag = neg ? -p : p;
        mag = (mag + (128'd1 << (n - 1))) >> n;
        lim = (128'd1 << (w - 1)) - (neg ? 128'd0 : 128'd1);
        if (mag > lim) mag = lim;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic void add_point(longint p[3], bit done);
        point_t e;
        e.x = p[0][31:0];
        e.y = p[1][31:0];
        e.z = p[2][31:0];
        e.last = 1'b0;
        e.done = done;
        curve_pts.push_back(e);
    endfunction

    function automatic void sample_segment(bit has_p0, longint p0[3], longint p1[3],
                                           longint s1[3], longint p2[3], longint s2[3],
                                           bit has_p3, longint p3[3]);
        longint one;
        longint d01, d12, d23, g1, g2, g3, h;
        longint t, t2, t3, h00, h10, h01, h11, s;
        longint pt[3];
        int unsigned tv;
        one = longint'(1) <<< 14;
        for (int k = 0; k < 3; k++) begin
            d01 = has_p0 ? p1[k] - p0[k] : 0;
            d12 = p2[k] - p1[k];
            d23 = has_p3 ? p3[k] - p2[k] : 0;
            g1 = mul_rnd(d01, one + s1[2], 14, TANW);
            g2 = mul_rnd(d12, one - s1[2], 14, TANW);
            g3 = clamp(g2 - g1, TANW);
            h  = mul_rnd(g3, one + s1[1], 15, TANW);
            tan_out[k] = mul_rnd(clamp(g1 + h, TANW), one - s1[0], 14, TANW);
            g1 = mul_rnd(d12, one + s2[2], 14, TANW);
            g2 = mul_rnd(d23, one - s2[2], 14, TANW);
            g3 = clamp(g2 - g1, TANW);
            h  = mul_rnd(g3, one - s2[1], 15, TANW);
            tan_in[k] = mul_rnd(clamp(g1 + h, TANW), one - s2[0], 14, TANW);
        end
        for (int i = 0; i < int'(seg_samples); i++) begin
            tv  = i * int'(t_inc);
            t   = tv > 65536 ? 65536 : tv;
            t2  = mul_rnd(t, t, 16, 40);
            t3  = mul_rnd(t2, t, 16, 40);
            h00 = 2 * t3 - 3 * t2 + 65536;
            h10 = t3 - 2 * t2 + t;
            h01 = 3 * t2 - 2 * t3;
            h11 = t3 - t2;
            for (int k = 0; k < 3; k++) begin
                s = mul_rnd(p1[k], h00, 16, 62) + mul_rnd(tan_out[k], h10, 16, 62)
                  + mul_rnd(p2[k], h01, 16, 62) + mul_rnd(tan_in[k], h11, 16, 62);
                pt[k] = clamp(s, 32);
            end
            add_point(pt, 1'b0);
        end
    endfunction

    function automatic void take_knot(logic [143:0] d, logic fin);
        longint q[3];
        longint qs[3];
        int     base;
        point_t e;
        q[0]  = longint'($signed(d[31:0]));
        q[1]  = longint'($signed(d[63:32]));
        q[2]  = longint'($signed(d[95:64]));
        qs[0] = longint'($signed(d[111:96]));
        qs[1] = longint'($signed(d[127:112]));
        qs[2] = longint'($signed(d[143:128]));
        base = curve_pts.size();
        if (knot_cnt >= 2)
            sample_segment(knot_cnt == 3, win_pos[0], win_pos[1], win_shape[1],
                           win_pos[2], win_shape[2], 1'b1, q);
        if (fin && knot_cnt >= 1) begin
            sample_segment(knot_cnt >= 2, win_pos[1], win_pos[2], win_shape[2],
                           q, qs, 1'b0, q);
            add_point(q, 1'b1);
        end
        if (fin) begin
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++) begin
                    win_pos[i][k]   = 0;
                    win_shape[i][k] = 0;
                end
            knot_cnt = 0;
        end else begin
            for (int i = 0; i < 2; i++)
                for (int k = 0; k < 3; k++) begin
                    win_pos[i][k]   = win_pos[i+1][k];
                    win_shape[i][k] = win_shape[i+1][k];
                end
            for (int k = 0; k < 3; k++) begin
                win_pos[2][k]   = q[k];
                win_shape[2][k] = qs[k];
            end
            if (knot_cnt < 3) knot_cnt++;
        end
        if (curve_pts.size() > base) begin
            e = curve_pts.pop_back();
            e.last = 1'b1;
            curve_pts.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        point_t e;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++) begin
                    win_pos[i][k]   = 0;
                    win_shape[i][k] = 0;
                end
            knot_cnt    = 0;
            seg_samples = SPP_RESET;
            t_inc       = TSTEP_RESET;
            fails       = 0;
            curve_pts.delete();
        end else begin
            if (i_pt_valid && i_pt_ready) begin
                if (curve_pts.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected point transfer: %h last=%b done=%b",
                                 i_pt_data, i_pt_last, i_pt_done);
                end else begin
                    e = curve_pts.pop_front();
                    if (i_pt_data[31:0] !== e.x || i_pt_data[63:32] !== e.y ||
                        i_pt_data[95:64] !== e.z || i_pt_last !== e.last ||
                        i_pt_done !== e.done) begin
                        fails++;
                        if (fails <= 10)
                            $display("point mismatch: exp %h %h %h l=%b d=%b got %h %h %h l=%b d=%b",
                                     e.x, e.y, e.z, e.last, e.done, i_pt_data[31:0],
                                     i_pt_data[63:32], i_pt_data[95:64], i_pt_last, i_pt_done);
                    end
                end
            end
            if (i_knot_valid && i_knot_ready)
                take_knot(i_knot_data, i_knot_final);
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_SPP)   seg_samples = i_cfg_wdata[4:0];
                if (i_cfg_addr == CFG_TSTEP) t_inc = i_cfg_wdata[16:0];
            end
        end
    end

endmodule

// File: tb/tcb_spline_segment_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcb_spline_segment_sampler_tb
// Feeds knot curves to the spline sampler: directed edge cases first, then
// random curves under several point counts and step sizes, with random gaps
// on the knot side and random stalls on the point side.
// ----------------------------------------------------------------------------
module tcb_spline_segment_sampler_tb;
    import tcbs_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [143:0]         s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [95:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = '0;
    logic [CFG_DW-1:0]    i_cfg_wdata = '0;
    int                   fail_count;
    int                   pending;
    int                   knots_sent = 0;
    bit                   stall_long = 1'b0;

    always #5 i_clk = ~i_clk;

    tcb_spline_segment_sampler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    tcb_spline_segment_sampler_chk i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_knot_valid(s_axis_tvalid), .i_knot_ready(s_axis_tready),
        .i_knot_data(s_axis_tdata), .i_knot_final(s_axis_tlast),
        .i_pt_valid(m_axis_tvalid), .i_pt_ready(m_axis_tready),
        .i_pt_data(m_axis_tdata), .i_pt_last(m_axis_tlast), .i_pt_done(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // point-side stalls: runs of ready and runs of stall
    initial begin
        int n;
        forever begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            n = stall_long ? $urandom_range(5, 40) : gap_len();
            repeat (n) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    task automatic send_knot(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [15:0] ten, logic [15:0] con, logic [15:0] bia,
                             logic fin);
        int g;
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bia, con, ten, z, y, x};
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        knots_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_config(logic [4:0] spp, logic [16:0] step);
        wait_idle();
        write_reg(CFG_SPP, CFG_DW'(spp));
        write_reg(CFG_TSTEP, step);
    endtask

    function automatic logic [31:0] rnd_coord(bit wide);
        if (wide) return $urandom;
        return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    endfunction

    function automatic logic [15:0] rnd_shape();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 32768)) - 16'd16384;
    endfunction

    task automatic random_curve(int n);
        bit wide;
        wide = $urandom_range(0, 7) == 0;
        for (int i = 0; i < n; i++)
            send_knot(rnd_coord(wide), rnd_coord(wide), rnd_coord(wide),
                      rnd_shape(), rnd_shape(), rnd_shape(), i == n - 1);
    endtask

    initial begin
        int spp;
        int phase_items;
        int lim;
        logic [16:0] step;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-knot curve, then a two-knot curve at reset settings
        send_knot(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'd0, 16'd0, 16'd0, 1'b1);
        send_knot(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd0, 16'd0, 16'd0, 1'b0);
        send_knot(32'h0004_0000, 32'hFFFC_0000, 32'h0001_8000, 16'd8192, 16'hE000,
                  16'd4096, 1'b1);
        // coordinate and shape extremes, shapes beyond nominal
        send_knot(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'd16384, 16'hC000,
                  16'd16384, 1'b0);
        send_knot(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hC000, 16'd16384,
                  16'hC000, 1'b0);
        send_knot(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000,
                  16'h7FFF, 1'b0);
        send_knot(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF,
                  16'h8000, 1'b1);
        // no points per segment: endpoint only
        set_config(5'd0, 17'd4096);
        random_curve(3);
        // one point per segment, full step
        set_config(5'd1, 17'd65536);
        random_curve(3);
        // many points, t runs past one
        set_config(5'd31, 17'h1FFFF);
        random_curve(3);
        set_config(5'd5, 17'd1);
        random_curve(2);
        set_config(5'd3, 17'd0);
        random_curve(2);

        while (knots_sent < 130) begin
            case ($urandom_range(0, 9))
                0: spp = 0;
                1: spp = 31;
                default: spp = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 7))
                0: step = 17'd1;
                1: step = 17'd65536;
                2: step = 17'($urandom);
                default: step = 17'(65536 / (spp == 0 ? 1 : spp));
            endcase
            set_config(5'(spp), step);
            stall_long = $urandom_range(0, 3) == 0;
            lim = spp == 31 ? 6 : 22;
            phase_items = 0;
            while (phase_items < lim) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: lone knots and two-knot curves
                    random_curve($urandom_range(1, 2));
                    phase_items += 2;
                end else begin
                    spp = $urandom_range(3, 8);
                    random_curve(spp);
                    phase_items += spp;
                end
            end
        end

        wait_idle();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
